@@ sv/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    // Fixed field widths of the channel payloads
    localparam int unsigned VALUE_BITS = 64;
    localparam int unsigned CHAR_BITS  = 6;

    // Character codes, truncated to six bits
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 6'd45;
    // Digit d encodes as 48 + d, that is 2'b11 above the BCD nibble
    localparam logic [1:0]           CHAR_DIGIT_HI = 2'b11;

    // Mode bit codes
    localparam logic MODE_SIGNED   = 1'b0;
    localparam logic MODE_UNSIGNED = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_STRIP,
        ST_EMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture a new number
        logic convert;  // one shift-add-3 step
        logic strip;    // drop one leading zero digit
        logic emit;     // push one character to the output register
    } t_ctrl_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic conv_last;   // the current convert step consumes the final bit
        logic strip_more;  // a leading zero digit is still present
        logic out_free;    // output register can take a character this cycle
        logic emit_last;   // the character being emitted ends the number
    } t_ctrl_sts;

endpackage

@@ sv/itoa_in_if.sv @@
// ----------------------------------------------------------------------------
// itoa_in_if
// Input stream: one integer pattern and its mode bit per transaction.
// ----------------------------------------------------------------------------
interface itoa_in_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::VALUE_BITS-1:0]     value_bits;
    logic                                opcode;

    modport source (output valid, output value_bits, output opcode, input ready);
    modport sink   (input valid, input value_bits, input opcode, output ready);
endinterface

@@ sv/itoa_out_if.sv @@
// ----------------------------------------------------------------------------
// itoa_out_if
// Output stream: one ASCII character per transaction, last marks the end.
// ----------------------------------------------------------------------------
interface itoa_out_if;
    logic                                valid;
    logic                                ready;
    logic [itoa_pkg::CHAR_BITS-1:0]      character;
    logic                                last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

@@ sv/itoa_datapath.sv @@
// ----------------------------------------------------------------------------
// itoa_datapath
// Magnitude register, double-dabble BCD converter, digit strip and output
// character register.
// ----------------------------------------------------------------------------
module itoa_datapath #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_CHARS   = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  itoa_pkg::t_ctrl_cmd               i_cmd,
    output itoa_pkg::t_ctrl_sts               o_sts,
    input  logic [itoa_pkg::VALUE_BITS-1:0]   i_value_bits,
    input  logic                              i_opcode,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [itoa_pkg::CHAR_BITS-1:0]    o_character,
    output logic                              o_last
);
    import itoa_pkg::*;

    // Decimal digits of 2**VALUE_WIDTH - 1: floor(W * log10(2)) + 1
    localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int unsigned BCD_W      = NUM_DIGITS * 4;
    localparam int unsigned BIT_CNT_W  = $clog2(VALUE_WIDTH);
    localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS + 1);
    localparam int unsigned CHR_CNT_W  = $clog2(MAX_CHARS);

    logic [VALUE_WIDTH-1:0] r_bin,      n_bin;
    logic [BCD_W-1:0]       r_bcd,      n_bcd;
    logic                   r_neg,      n_neg;
    logic [BIT_CNT_W-1:0]   r_bit_cnt,  n_bit_cnt;
    logic [DIG_CNT_W-1:0]   r_dig_left, n_dig_left;
    logic [CHR_CNT_W-1:0]   r_chr_cnt,  n_chr_cnt;
    logic                   r_out_valid, n_out_valid;
    logic [CHAR_BITS-1:0]   r_char,     n_char;
    logic                   r_last,     n_last;

    logic [VALUE_WIDTH-1:0] in_pattern;
    logic                   in_negative;
    logic [BCD_W-1:0]       bcd_adj;
    logic [3:0]             top_digit;
    logic                   emit_last;

    // Input magnitude: unsigned two's complement negation covers the most
    // negative value
    assign in_pattern  = i_value_bits[VALUE_WIDTH-1:0];
    assign in_negative = (i_opcode == MODE_SIGNED) && in_pattern[VALUE_WIDTH-1];

    // Add 3 to each digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    assign top_digit = r_bcd[BCD_W-1 -: 4];

    // Final character: last digit, or the character limit reached
    assign emit_last = (!r_neg && (r_dig_left == DIG_CNT_W'(1)))
                    || (r_chr_cnt == CHR_CNT_W'(MAX_CHARS - 1));

    // Status toward the controller
    always_comb begin
        o_sts.conv_last  = (r_bit_cnt == BIT_CNT_W'(VALUE_WIDTH - 1));
        o_sts.strip_more = (top_digit == 4'd0) && (r_dig_left > DIG_CNT_W'(1));
        o_sts.out_free   = !r_out_valid || i_out_ready;
        o_sts.emit_last  = emit_last;
    end

    // Next values of the working registers
    always_comb begin
        n_bin       = r_bin;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_bit_cnt   = r_bit_cnt;
        n_dig_left  = r_dig_left;
        n_chr_cnt   = r_chr_cnt;
        n_char      = r_char;
        n_last      = r_last;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.load) begin
            n_bin      = in_negative ? (~in_pattern + VALUE_WIDTH'(1)) : in_pattern;
            n_neg      = in_negative;
            n_bcd      = '0;
            n_bit_cnt  = '0;
            n_dig_left = DIG_CNT_W'(NUM_DIGITS);
            n_chr_cnt  = '0;
        end

        if (i_cmd.convert) begin
            n_bcd     = {bcd_adj[BCD_W-2:0], r_bin[VALUE_WIDTH-1]};
            n_bin     = {r_bin[VALUE_WIDTH-2:0], 1'b0};
            n_bit_cnt = r_bit_cnt + BIT_CNT_W'(1);
        end

        if (i_cmd.strip) begin
            n_bcd      = {r_bcd[BCD_W-5:0], 4'd0};
            n_dig_left = r_dig_left - DIG_CNT_W'(1);
        end

        // Sign first, then digits from the top of the BCD word
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_last      = emit_last;
            n_chr_cnt   = r_chr_cnt + CHR_CNT_W'(1);
            if (r_neg) begin
                n_char = CHAR_MINUS;
                n_neg  = 1'b0;
            end else begin
                n_char     = {CHAR_DIGIT_HI, top_digit};
                n_bcd      = {r_bcd[BCD_W-5:0], 4'd0};
                n_dig_left = r_dig_left - DIG_CNT_W'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and working registers
    always_ff @(posedge i_clk) begin
        r_bin      <= n_bin;
        r_bcd      <= n_bcd;
        r_neg      <= n_neg;
        r_bit_cnt  <= n_bit_cnt;
        r_dig_left <= n_dig_left;
        r_chr_cnt  <= n_chr_cnt;
        r_char     <= n_char;
        r_last     <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    // Never overwrite a character that has not been taken
    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("character emitted over a pending one");

    // Every emitted digit is a valid BCD digit
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_neg) |-> (top_digit <= 4'd9))
        else $error("non-decimal digit emitted");

    // A digit is emitted only while digits remain
    a_digits_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && !r_neg) |-> (r_dig_left != '0))
        else $error("digit emitted with none left");

endmodule

@@ sv/itoa_ctrl.sv @@
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, convert one bit per cycle, strip leading zeros, emit.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  itoa_pkg::t_ctrl_sts  i_sts,
    output itoa_pkg::t_ctrl_cmd  o_cmd
);
    import itoa_pkg::*;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                if (i_sts.conv_last) begin
                    n_state = ST_STRIP;
                end
            end
            ST_STRIP: begin
                if (!i_sts.strip_more) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free && i_sts.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_CONVERT: begin
                o_cmd.convert = 1'b1;
            end
            ST_STRIP: begin
                o_cmd.strip = i_sts.strip_more;
            end
            ST_EMIT: begin
                o_cmd.emit = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A load always starts a conversion
    a_load_to_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_CONVERT))
        else $error("load did not start conversion");

    // Input is taken only when no number is in flight
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.convert || o_cmd.strip || o_cmd.emit) |-> !o_in_ready)
        else $error("input ready while busy");

    // Only one datapath command per cycle
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("overlapping datapath commands");

endmodule

@@ sv/integer_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core
// Prints one integer, signed or unsigned, as decimal ASCII characters.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Payload                     | Transaction
//  i_in     | in  | value_bits[63:0], opcode    | one integer and its mode
//  o_out    | out | character[5:0], last        | one ASCII character
//
//  A number passes through a load, VALUE_WIDTH shift-add-3 conversion steps,
//  one strip step per leading zero digit dropped, and one emit step per
//  character.
//  Reset clears the sequencer and the output valid; no clearing pass.
//  A stalled output holds the emit loop; the next number is accepted while
//  the final character still waits in the output register.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_core #(
    parameter int unsigned VALUE_WIDTH = 64,
    parameter int unsigned MAX_CHARS   = 20
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);
    import itoa_pkg::*;

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    // Sequencer
    itoa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Conversion datapath and output register
    itoa_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_CHARS   (MAX_CHARS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_value_bits (i_in.value_bits),
        .i_opcode     (i_in.opcode),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_character  (o_out.character),
        .o_last       (o_out.last)
    );

endmodule
